/* hdl/iptm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IR pulse-train matcher package
// Shared payload types, configuration layout and counter constants.
// ---------------------------------------------------------------------------
package iptm_pkg;

	// Largest pulse count per train; the match counter saturates here
	localparam int MAX_PULSES = 1024;
	localparam int CNT_W      = 11;
	localparam logic [CNT_W-1:0] CNT_LIMIT =
		(MAX_PULSES > 2047) ? 11'd2047 : 11'(MAX_PULSES);

	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MIN_TOLERANCE   = 2'd0,
		CFG_TOL_PERCENT     = 2'd1,
		CFG_MAX_LEN_DIFF    = 2'd2,
		CFG_MATCH_PERCENT   = 2'd3
	} iptm_cfg_idx_t;

	typedef struct packed {
		logic [15:0] min_tolerance;
		logic [6:0]  tolerance_percent;
		logic [10:0] max_length_difference;
		logic [6:0]  match_percent;
	} iptm_cfg_t;

	// Input item
	typedef struct packed {
		logic signed [15:0] pulse_a;
		logic signed [15:0] pulse_b;
		logic               pair_present;
		logic               last_pair;
		logic [10:0]        length_a;
		logic [10:0]        length_b;
	} iptm_in_t;

	// Result item
	typedef struct packed {
		logic        code_matches;
		logic [10:0] matched_pairs;
		logic [10:0] compared_pairs;
	} iptm_out_t;

	// Values handed from the front stage to the tally stage
	typedef struct packed {
		logic [15:0] diff;
		logic [22:0] diff_x100;
		logic [22:0] tol_prod;
		logic        present;
		logic        last;
		logic        len_ok;
		logic [10:0] shorter;
		logic [17:0] need;
	} iptm_s2_t;

endpackage

/* hdl/iptm_cfg_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Configuration registers
// Write-only register file for tolerances and match thresholds.
// ---------------------------------------------------------------------------
module iptm_cfg_regs
	import iptm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  iptm_cfg_idx_t         cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output iptm_cfg_t             cfg
);

	iptm_cfg_t cfg_q;

	// Register writes, reset to defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_tolerance         <= 16'd250;
			cfg_q.tolerance_percent     <= 7'd35;
			cfg_q.max_length_difference <= 11'd4;
			cfg_q.match_percent         <= 7'd85;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_TOLERANCE: cfg_q.min_tolerance         <= cfg_wdata;
				CFG_TOL_PERCENT:   cfg_q.tolerance_percent     <= cfg_wdata[6:0];
				CFG_MAX_LEN_DIFF:  cfg_q.max_length_difference <= cfg_wdata[10:0];
				CFG_MATCH_PERCENT: cfg_q.match_percent         <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/iptm_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Front stages
// Input register, then pulse difference, tolerance product and length checks.
// ---------------------------------------------------------------------------
module iptm_front
	import iptm_pkg::*;
(
	input  logic      clk,
	input  logic      load_s1,
	input  logic      load_s2,
	input  iptm_in_t  in_data,
	input  iptm_cfg_t cfg,
	output iptm_s2_t  data_s2
);

	iptm_in_t  item_s1;
	iptm_s2_t  next_s2;
	iptm_s2_t  reg_s2;

	logic signed [16:0] a_ext, b_ext, a_neg, b_neg, d_ext, d_neg;
	logic [15:0]        mag_a, mag_b, big;
	logic [10:0]        ldiff;

	// Input register
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= in_data;
		end
	end

	// Magnitudes, difference, scaled tolerance, length checks
	always_comb begin
		a_ext = {item_s1.pulse_a[15], item_s1.pulse_a};
		b_ext = {item_s1.pulse_b[15], item_s1.pulse_b};
		a_neg = -a_ext;
		b_neg = -b_ext;
		d_ext = a_ext - b_ext;
		d_neg = -d_ext;
		mag_a = a_ext[16] ? a_neg[15:0] : a_ext[15:0];
		mag_b = b_ext[16] ? b_neg[15:0] : b_ext[15:0];
		big   = (mag_a > mag_b) ? mag_a : mag_b;

		next_s2.diff      = d_ext[16] ? d_neg[15:0] : d_ext[15:0];
		// diff * 100 = diff*64 + diff*32 + diff*4
		next_s2.diff_x100 = ({7'd0, next_s2.diff} << 6) + ({7'd0, next_s2.diff} << 5)
			+ ({7'd0, next_s2.diff} << 2);
		next_s2.tol_prod  = 23'(big) * 23'(cfg.tolerance_percent);
		next_s2.present   = item_s1.pair_present;
		next_s2.last      = item_s1.last_pair;

		ldiff = (item_s1.length_a > item_s1.length_b) ?
			item_s1.length_a - item_s1.length_b : item_s1.length_b - item_s1.length_a;
		next_s2.len_ok  = (ldiff <= cfg.max_length_difference);
		next_s2.shorter = (item_s1.length_a < item_s1.length_b) ?
			item_s1.length_a : item_s1.length_b;
		next_s2.need    = 18'(cfg.match_percent) * 18'(next_s2.shorter);
	end

	// Second stage register
	always_ff @(posedge clk) begin
		if (load_s2) begin
			reg_s2 <= next_s2;
		end
	end

	assign data_s2 = reg_s2;

endmodule

/* hdl/iptm_tally.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tally stage
// Pair match decision, saturating match counter, verdict and result register.
// ---------------------------------------------------------------------------
module iptm_tally
	import iptm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance_s2,
	input  iptm_s2_t  data_s2,
	input  iptm_cfg_t cfg,
	input  logic      out_ready,
	output logic      out_valid,
	output iptm_out_t out_data,
	output logic      out_free
);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             close;
	logic [17:0]      count_x100;
	logic             verdict;
	logic             out_valid_q;
	iptm_out_t        out_data_q;

	// Pair compare: diff <= max(min_tol, floor(prod/100))
	always_comb begin
		close = data_s2.present &&
			(({7'd0, data_s2.diff} <= 23'(cfg.min_tolerance)) ||
			 (data_s2.diff_x100 <= data_s2.tol_prod));
		count_next = (close && (count_q < CNT_LIMIT)) ? count_q + 11'd1 : count_q;
		count_x100 = ({7'd0, count_next} << 6) + ({7'd0, count_next} << 5)
			+ ({7'd0, count_next} << 2);
		verdict = data_s2.len_ok && (data_s2.shorter != 11'd0) &&
			(count_x100 >= data_s2.need);
	end

	// Match counter, cleared after each last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance_s2) begin
			count_q <= data_s2.last ? '0 : count_next;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s2 && data_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && data_s2.last) begin
			out_data_q.code_matches   <= verdict;
			out_data_q.matched_pairs  <= count_next;
			out_data_q.compared_pairs <= data_s2.shorter;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* hdl/ir_pulse_train_matcher_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IR pulse-train matcher
// Compares two raw IR pulse trains pair by pair and judges whether they match.
// ---------------------------------------------------------------------------
// One pulse pair is taken per clock unless stalled. Items pass three stages:
// - an input register
// - a stage that forms the pulse difference and the tolerance product
// - a tally stage that updates the saturating match counter
// An item marked last has its result loaded into the output register when it
// leaves the tally stage, after the input and second stage registers. Items
// that are not last give no result and need no free output register.
// Throughput is one item per cycle while results are taken. A stalled result
// holds back only the next last item and the items queued behind it.
// Configuration writes must be made while idle.
// ---------------------------------------------------------------------------
module ir_pulse_train_matcher_core
	import iptm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  iptm_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output iptm_out_t             out_data,
	input  logic                  cfg_we,
	input  iptm_cfg_idx_t         cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	iptm_cfg_t cfg;
	iptm_s2_t  data_s2;
	logic      valid_s1, valid_s2;
	logic      advance_s1, advance_s2, out_free, in_xfer;

	iptm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Flow control: last items need a free result register
	always_comb begin
		advance_s2 = valid_s2 && (!data_s2.last || out_free);
		advance_s1 = valid_s1 && (!valid_s2 || advance_s2);
		in_ready   = !valid_s1 || advance_s1;
		in_xfer    = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || advance_s2) begin
				valid_s2 <= advance_s1;
			end
		end
	end

	iptm_front u_front (
		.clk     (clk),
		.load_s1 (in_xfer),
		.load_s2 (advance_s1),
		.in_data (in_data),
		.cfg     (cfg),
		.data_s2 (data_s2)
	);

	iptm_tally u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance_s2 (advance_s2),
		.data_s2    (data_s2),
		.cfg        (cfg),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.out_data   (out_data),
		.out_free   (out_free)
	);

endmodule

/* hdl/iptm_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IR pulse-train matcher checker
// Port-level properties of the matcher core, bound to the top level.
// ---------------------------------------------------------------------------
module iptm_checker
	import iptm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input iptm_out_t out_data
);

	// Reset empties the result register
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// Counter never passes its saturation limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.matched_pairs <= CNT_LIMIT)
		else $error("matched count above limit");

	// A match verdict needs a nonzero shorter length
	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.code_matches |-> out_data.compared_pairs != 11'd0)
		else $error("match reported with empty train");

endmodule

bind ir_pulse_train_matcher_core iptm_checker u_iptm_checker (.*);

/* tb/ir_pulse_train_matcher_core_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// IR pulse-train matcher testbench
// Streams pulse pairs and closing items through the matcher under several
// register settings, with random gaps on both handshakes. A scoreboard keeps
// its own match counter and register copies, predicts each verdict and checks
// every result transfer field by field.
// ---------------------------------------------------------------------------
module ir_pulse_train_matcher_core_tb;
	import iptm_pkg::*;

	// Predicts verdicts from accepted pairs and checks result transfers
	class verdict_scoreboard;
		logic [15:0]      min_tol;
		logic [6:0]       tol_pct;
		logic [10:0]      len_diff_max;
		logic [6:0]       match_pct;
		logic [CNT_W-1:0] match_count;
		iptm_out_t        verdicts_due[$];
		int               mismatches;

		function new();
			min_tol      = 16'd250;
			tol_pct      = 7'd35;
			len_diff_max = 11'd4;
			match_pct    = 7'd85;
			match_count  = '0;
			mismatches   = 0;
		endfunction

		function void write_reg(iptm_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_MIN_TOLERANCE: min_tol      = data[15:0];
				CFG_TOL_PERCENT:   tol_pct      = data[6:0];
				CFG_MAX_LEN_DIFF:  len_diff_max = data[10:0];
				CFG_MATCH_PERCENT: match_pct    = data[6:0];
				default: ;
			endcase
		endfunction

		function bit pulses_close(logic signed [15:0] a, logic signed [15:0] b);
			int diff, mag_a, mag_b, big, tol;
			diff  = int'(a) - int'(b);
			diff  = (diff < 0) ? -diff : diff;
			mag_a = (a < 0) ? -int'(a) : int'(a);
			mag_b = (b < 0) ? -int'(b) : int'(b);
			big   = (mag_a > mag_b) ? mag_a : mag_b;
			tol   = (big * int'(tol_pct)) / 100;
			if (tol < int'(min_tol))
				tol = int'(min_tol);
			return diff <= tol;
		endfunction

		// Accepted input: update the counter, queue a verdict on a last item
		function void note_transfer(iptm_in_t item);
			iptm_out_t verdict;
			int len_a, len_b, len_diff, shorter;
			if (item.pair_present && pulses_close(item.pulse_a, item.pulse_b))
				if (match_count < CNT_LIMIT)
					match_count++;
			if (item.last_pair) begin
				len_a    = int'(item.length_a);
				len_b    = int'(item.length_b);
				len_diff = (len_a > len_b) ? len_a - len_b : len_b - len_a;
				shorter  = (len_a < len_b) ? len_a : len_b;
				verdict.code_matches   = (len_diff <= int'(len_diff_max)) && (shorter != 0) &&
					(int'(match_count) * 100 >= int'(match_pct) * shorter);
				verdict.matched_pairs  = match_count;
				verdict.compared_pairs = 11'(shorter);
				verdicts_due.push_back(verdict);
				match_count = '0;
			end
		endfunction

		function int pending();
			return verdicts_due.size();
		endfunction

		function void check_result(iptm_out_t got);
			iptm_out_t want;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result code_matches=%0d matched=%0d compared=%0d",
					$time, got.code_matches, got.matched_pairs, got.compared_pairs);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.code_matches !== want.code_matches) begin
				mismatches++;
				$display("%0t: code_matches expected %0d actual %0d",
					$time, want.code_matches, got.code_matches);
			end
			if (got.matched_pairs !== want.matched_pairs) begin
				mismatches++;
				$display("%0t: matched_pairs expected %0d actual %0d",
					$time, want.matched_pairs, got.matched_pairs);
			end
			if (got.compared_pairs !== want.compared_pairs) begin
				mismatches++;
				$display("%0t: compared_pairs expected %0d actual %0d",
					$time, want.compared_pairs, got.compared_pairs);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	iptm_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	iptm_out_t             out_data;
	logic                  cfg_we;
	iptm_cfg_idx_t         cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	verdict_scoreboard sb;
	bit                no_idle;

	ir_pulse_train_matcher_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	// Transfer monitor: results are checked before the same-edge input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (in_valid && in_ready)
				sb.note_transfer(in_data);
		end
	end

	// Result side: random stall before each transfer
	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic iptm_in_t pair_item(int a, int b, bit present, bit last,
		int len_a, int len_b);
		iptm_in_t item;
		item.pulse_a      = 16'(a);
		item.pulse_b      = 16'(b);
		item.pair_present = present;
		item.last_pair    = last;
		item.length_a     = 11'(len_a);
		item.length_b     = 11'(len_b);
		return item;
	endfunction

	// Present one item after a random gap and hold it until the transfer
	task automatic send_item(input iptm_in_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold off input until every verdict is in, then let the pipeline empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all four registers back to back; junk above each narrower register width
	task automatic program_regs(input int min_tol, input int tol_pct,
		input int len_diff, input int match_pct);
		int vals[4];
		int widths[4];
		logic [CFG_DATA_W-1:0] word;
		vals   = '{min_tol, tol_pct, len_diff, match_pct};
		widths = '{16, 7, 11, 7};
		for (int i = 0; i < 4; i++) begin
			word = (16'($urandom) << widths[i]) | 16'(vals[i] & ((1 << widths[i]) - 1));
			cfg_we    <= 1'b1;
			cfg_index <= iptm_cfg_idx_t'(i);
			cfg_wdata <= word;
			@(posedge clk);
			sb.write_reg(iptm_cfg_idx_t'(i), word);
		end
		cfg_we <= 1'b0;
	endtask

	// Random pulse trains: mostly similar pulse pairs closed by a last item,
	// some noise items and some broken length fields
	task automatic run_trains(input int n_items);
		int sent, pairs, mode, span, a, b, len_a, len_b;
		bit closing_empty;
		iptm_in_t item;
		sent = 0;
		while (sent < n_items) begin
			pairs         = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
				: $urandom_range(1, 16);
			closing_empty = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < pairs + closing_empty; i++) begin
				mode = $urandom_range(0, 9);
				if (mode < 2) begin
					a = int'($urandom);
					b = int'($urandom);
				end else begin
					a    = (mode < 6) ? $urandom_range(0, 3000) : $urandom_range(0, 32767);
					span = a * 40 / 100 + 300;
					if ($urandom_range(0, 1))
						a = -a;
					b = a + $urandom_range(0, 2 * span) - span;
				end
				item = pair_item(a, b, 1'b1, 1'b0, $urandom_range(0, 2047),
					$urandom_range(0, 2047));
				if (i == pairs || $urandom_range(0, 15) == 0)
					item.pair_present = 1'b0;
				if (i == pairs + closing_empty - 1) begin
					item.last_pair = 1'b1;
					case ($urandom_range(0, 9))
						0: begin
							len_a = $urandom_range(0, 2047);
							len_b = $urandom_range(0, 2047);
						end
						1: begin
							len_a = 0;
							len_b = $urandom_range(0, 3);
						end
						default: begin
							len_a = pairs + $urandom_range(0, 3);
							len_b = pairs + $urandom_range(0, 12) - 6;
							if (len_b < 0)
								len_b = 0;
						end
					endcase
					item.length_a = 11'(len_a);
					item.length_b = 11'(len_b);
				end
				send_item(item);
				sent++;
			end
		end
	endtask

	// Main sequence
	initial begin : stimulus
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_MIN_TOLERANCE;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		no_idle   = 1'b0;
		sb        = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at reset register values
		send_item(pair_item(250, 0, 1, 0, 0, 0));         // at min tolerance
		send_item(pair_item(251, 0, 1, 0, 0, 0));         // just past it
		send_item(pair_item(32767, -32768, 1, 0, 0, 0));  // widest difference
		send_item(pair_item(-32768, -32768, 1, 0, 0, 0));
		send_item(pair_item(10000, 16000, 1, 0, 0, 0));   // past percent tolerance
		send_item(pair_item(10000, 15000, 1, 0, 0, 0));   // within percent tolerance
		send_item(pair_item(1234, -1234, 0, 0, 0, 0));    // pulses ignored
		send_item(pair_item(0, 0, 1, 1, 3, 3));           // train matches
		send_item(pair_item(0, 0, 0, 1, 0, 0));           // zero shorter length
		send_item(pair_item(5, 5, 1, 1, 1024, 1020));     // too few matches
		send_item(pair_item(5, 5, 1, 1, 1, 6));           // lengths too different
		send_item(pair_item(-1, 1, 1, 1, 2047, 2047));
		send_item(pair_item(7, 7, 0, 1, 1, 1));           // empty closing item
		send_item(pair_item(100, -100, 1, 1, 1, 2));
		drain();

		// Register settings, extremes first
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: program_regs(0, 0, 0, 0);
				1: program_regs(65535, 127, 2047, 127);
				2: program_regs(0, 100, 1024, 100);
				3: program_regs(250, 35, 4, 85);
				default: program_regs($urandom_range(0, 2000), $urandom_range(0, 100),
					$urandom_range(0, 8), $urandom_range(50, 100));
			endcase
			no_idle = (phase == 2);
			run_trains(130);
			drain();
		end
		no_idle = 1'b0;

		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
hdl/iptm_pkg.sv
hdl/iptm_cfg_regs.sv
hdl/iptm_front.sv
hdl/iptm_tally.sv
hdl/ir_pulse_train_matcher_core.sv
hdl/iptm_checker.sv
tb/ir_pulse_train_matcher_core_tb.sv
